// ----- src/ncs_pkg.sv -----
package ncs_pkg;

  // Palette size; storage and index widths follow from it.
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned ADDR_W = $clog2(PALETTE_ENTRIES);

  localparam int unsigned CH_W   = 8;   // one colour channel
  localparam int unsigned IDX_W  = 8;   // index field width
  localparam int unsigned DIST_W = 25;  // distance field width
  localparam int unsigned SQ_W   = 2 * CH_W;
  localparam int unsigned SUM_W  = SQ_W + 2;  // sum of three squares

  // Reported when no entry is marked used; no real distance reaches it.
  localparam logic [DIST_W-1:0] NO_MATCH_DISTANCE = DIST_W'(256 * 256 * 256);

  // Item codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // one palette store word: used flag beside the colour
  typedef struct packed {
    logic used;
    rgb_t rgb;
  } entry_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             entry_used;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]  nearest_index;
    logic [DIST_W-1:0] nearest_distance;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLEAR = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

// ----- src/ncs_ram.sv -----
module ncs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ncs_dist.sv -----
module ncs_dist (
  input  logic                      clk_i,
  input  ncs_pkg::rgb_t             color_i,
  input  ncs_pkg::rgb_t             entry_i,
  output logic [ncs_pkg::SUM_W-1:0] dist_o
);

  logic [ncs_pkg::CH_W-1:0] dr, dg, db;
  logic [ncs_pkg::SQ_W-1:0] sq_r_q, sq_g_q, sq_b_q;

  function automatic logic [ncs_pkg::CH_W-1:0] abs_diff(
    input logic [ncs_pkg::CH_W-1:0] a,
    input logic [ncs_pkg::CH_W-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    dr = abs_diff(color_i.red,   entry_i.red);
    dg = abs_diff(color_i.green, entry_i.green);
    db = abs_diff(color_i.blue,  entry_i.blue);
  end

  // squares registered; the sum is left to the compare stage
  always_ff @(posedge clk_i) begin
    sq_r_q <= ncs_pkg::SQ_W'(dr) * ncs_pkg::SQ_W'(dr);
    sq_g_q <= ncs_pkg::SQ_W'(dg) * ncs_pkg::SQ_W'(dg);
    sq_b_q <= ncs_pkg::SQ_W'(db) * ncs_pkg::SQ_W'(db);
  end

  assign dist_o = ncs_pkg::SUM_W'(sq_r_q) + ncs_pkg::SUM_W'(sq_g_q)
                + ncs_pkg::SUM_W'(sq_b_q);

endmodule

// ----- src/nearest_palette_color_search_unit.sv -----
// Channel   Direction  Signals                             Beat type
// in        input      in_valid_i  in_stall_o  in_data_i    ncs_pkg::in_beat_t
// out       output     out_valid_o out_stall_i out_data_o   ncs_pkg::out_beat_t
//
// Write and unused-code beats complete on acceptance; a clear beat zeroes one store
// word (flag and colour) per cycle with in_stall_o high.
// A query reads one store word per entry, then the read, square and compare stages
// drain and the done state loads the result; the next beat is taken in idle after that.
// Reset starts the same clearing pass, with in_stall_o high until it ends.
// A result waits in the output register under out_stall_i; a second query's result
// holds in the done state, input stalled, until that register frees.
module nearest_palette_color_search_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ncs_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ncs_pkg::out_beat_t out_data_o
);

  localparam int unsigned AW = ncs_pkg::ADDR_W;

  ncs_pkg::state_e state_q, state_d;

  logic            in_accept;
  logic            wr_in_range;
  logic            wr_beat;
  logic            clearing;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  ncs_pkg::entry_t ram_wdata;
  ncs_pkg::entry_t rd_entry;
  logic            scan;
  logic            scan_last;
  logic            out_free;
  logic            out_load;

  logic [AW-1:0] addr_q, addr_d;
  ncs_pkg::rgb_t color_q;

  // pipeline tags: read stage (p1) and square stage (p2)
  logic          p1_v_q, p2_v_q;
  logic          p2_used_q;
  logic [AW-1:0] p1_idx_q, p2_idx_q;

  logic [ncs_pkg::SUM_W-1:0]  entry_dist;
  logic [ncs_pkg::DIST_W-1:0] best_dist_q;
  logic [AW-1:0]              best_idx_q;
  logic                       better;

  logic               out_valid_q;
  ncs_pkg::out_beat_t out_data_q;

  // ---------------------------------------------------------------- handshake
  assign in_stall_o = (state_q != ncs_pkg::ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign wr_in_range = {1'b0, in_data_i.entry_index} < 9'(ncs_pkg::PALETTE_ENTRIES);
  assign wr_beat = in_accept && (in_data_i.func == ncs_pkg::FUNC_WRITE) && wr_in_range;

  // clearing pass owns the write port; otherwise a write beat uses it
  assign clearing  = (state_q == ncs_pkg::ST_CLEAR);
  assign ram_we    = wr_beat | clearing;
  assign ram_waddr = clearing ? addr_q : in_data_i.entry_index[AW-1:0];

  always_comb begin
    ram_wdata = '0;
    if (!clearing) begin
      ram_wdata.used      = in_data_i.entry_used;
      ram_wdata.rgb.red   = in_data_i.red;
      ram_wdata.rgb.green = in_data_i.green;
      ram_wdata.rgb.blue  = in_data_i.blue;
    end
  end

  assign scan      = (state_q == ncs_pkg::ST_SCAN);
  assign scan_last = (addr_q == AW'(ncs_pkg::PALETTE_ENTRIES - 1));

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign out_load = (state_q == ncs_pkg::ST_DONE) && out_free;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    unique case (state_q)
      ncs_pkg::ST_IDLE: begin
        addr_d = '0;
        if (in_accept && (in_data_i.func == ncs_pkg::FUNC_QUERY)) begin
          state_d = ncs_pkg::ST_SCAN;
        end else if (in_accept && (in_data_i.func == ncs_pkg::FUNC_CLEAR)) begin
          state_d = ncs_pkg::ST_CLEAR;
        end
      end
      ncs_pkg::ST_CLEAR: begin
        addr_d = addr_q + AW'(1);
        if (scan_last) begin
          state_d = ncs_pkg::ST_IDLE;
        end
      end
      ncs_pkg::ST_SCAN: begin
        addr_d = addr_q + AW'(1);
        if (scan_last) begin
          state_d = ncs_pkg::ST_DRAIN;
        end
      end
      ncs_pkg::ST_DRAIN: begin
        if (!p1_v_q && !p2_v_q) begin
          state_d = ncs_pkg::ST_DONE;
        end
      end
      ncs_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ncs_pkg::ST_IDLE;
        end
      end
      default: state_d = ncs_pkg::ST_IDLE;
    endcase
  end

  // reset lands in the clearing pass so every used flag starts low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncs_pkg::ST_CLEAR;
      addr_q  <= '0;
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      p1_v_q  <= scan;
      p2_v_q  <= p1_v_q;
    end
  end

  // ---------------------------------------------------------------- palette store
  ncs_ram #(
    .WIDTH ($bits(ncs_pkg::entry_t)),
    .DEPTH (ncs_pkg::PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (scan),
    .raddr_i (addr_q),
    .rdata_o (rd_entry)
  );

  // ---------------------------------------------------------------- distance
  ncs_dist u_dist (
    .clk_i   (clk_i),
    .color_i (color_q),
    .entry_i (rd_entry.rgb),
    .dist_o  (entry_dist)
  );

  // tags travel alongside the read and square stages
  always_ff @(posedge clk_i) begin
    p1_idx_q  <= addr_q;
    p2_used_q <= rd_entry.used;
    p2_idx_q  <= p1_idx_q;
  end

  // strict less-than keeps the lowest index on a tie
  assign better = p2_v_q && p2_used_q &&
                  (ncs_pkg::DIST_W'(entry_dist) < best_dist_q);

  always_ff @(posedge clk_i) begin
    if (in_accept && (in_data_i.func == ncs_pkg::FUNC_QUERY)) begin
      color_q.red   <= in_data_i.red;
      color_q.green <= in_data_i.green;
      color_q.blue  <= in_data_i.blue;
      best_dist_q   <= ncs_pkg::NO_MATCH_DISTANCE;
      best_idx_q    <= '0;
    end else if (better) begin
      best_dist_q <= ncs_pkg::DIST_W'(entry_dist);
      best_idx_q  <= p2_idx_q;
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.nearest_index    <= ncs_pkg::IDX_W'(best_idx_q);
      out_data_q.nearest_distance <= best_dist_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------- checks
  a_out_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ncs_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_best_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_v_q |=> (best_dist_q <= $past(best_dist_q)))
    else $error("best distance grew during a scan");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ncs_pkg::ST_IDLE) |-> (!p1_v_q && !p2_v_q))
    else $error("pipeline busy while idle");

  a_no_match_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.nearest_distance == ncs_pkg::NO_MATCH_DISTANCE))
    |-> (out_data_o.nearest_index == '0))
    else $error("no-match result with non-zero index");

endmodule
